FILE: rtl/core/point_in_polygon_box_occupancy_defines.svh
// Assertion macros shared by the point-in-polygon occupancy RTL.
`ifndef POINT_IN_POLYGON_BOX_OCCUPANCY_DEFINES_SVH
`define POINT_IN_POLYGON_BOX_OCCUPANCY_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define PIPBO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define PIPBO_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/pipbo_pkg.sv
// Constants, codes and types for the point-in-polygon occupancy block.
`timescale 1ns / 1ps

package pipbo_pkg;

  localparam int MAX_EDGES   = 64;
  localparam int MAX_BOXES   = 16;
  localparam int COORD_WIDTH = 16;

  localparam int EDGE_AW = $clog2(MAX_EDGES);
  localparam int BOX_AW  = $clog2(MAX_BOXES);

  localparam int ECNT_W  = 7;
  localparam int BCNT_W  = 5;
  localparam int OP_W    = 2;
  localparam int IDX_W   = 6;
  localparam int PADDR_W = 3;

  // Opcodes of the input channel.
  localparam logic [OP_W-1:0] OP_LOAD_EDGE = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_BOX  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY     = 2'd2;

  // Register indexes on the configuration port.
  localparam logic REG_EDGE_COUNT = 1'b0;
  localparam logic REG_BOX_COUNT  = 1'b1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // One table entry: edge (x1, y1, x2, y2) or box (cx, cy, w, h).
  typedef struct packed {
    coord_t a;
    coord_t b;
    coord_t c;
    coord_t d;
  } entry_t;

endpackage

FILE: rtl/core/point_in_polygon_box_occupancy.sv
// Point-in-polygon occupancy classifier: edge and box tables with a scan engine.
// A query scans NE = min(edge_count, 64) edges, then NB = min(box_count, 16) boxes,
// one memory read per cycle; out_valid rises once the last entry has been counted and
// the output slot is free, and holds until taken. The next item is taken once the
// result is registered; the table scan and the output slot set the rate.
// Reset (rst_n low, synchronous) clears both counts and the control; tables undefined.
`timescale 1ns / 1ps
`include "point_in_polygon_box_occupancy_defines.svh"

module point_in_polygon_box_occupancy (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pipbo_pkg::OP_W-1:0]        in_opcode,
  input  logic [pipbo_pkg::IDX_W-1:0]       in_entry_index,
  input  logic signed [pipbo_pkg::COORD_WIDTH-1:0] in_coord_a,
  input  logic signed [pipbo_pkg::COORD_WIDTH-1:0] in_coord_b,
  input  logic signed [pipbo_pkg::COORD_WIDTH-1:0] in_coord_c,
  input  logic signed [pipbo_pkg::COORD_WIDTH-1:0] in_coord_d,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_occupied,
  output logic [pipbo_pkg::ECNT_W-1:0]      out_crossing_count,
  output logic                              out_in_box,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pipbo_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import pipbo_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EDGE  = 2'd1;
  localparam logic [1:0] ST_BOX   = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ECNT_W-1:0] edge_count_r;
  logic [BCNT_W-1:0] box_count_r;
  logic              cfg_wr;
  logic              cfg_reg_sel;

  assign pready      = 1'b1;
  assign cfg_wr      = psel & penable & pwrite;
  assign cfg_reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_count_r <= '0;
      box_count_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_reg_sel)
        REG_EDGE_COUNT: edge_count_r <= pwdata[ECNT_W-1:0];
        REG_BOX_COUNT:  box_count_r  <= pwdata[BCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_sel)
      REG_EDGE_COUNT: prdata = 32'(edge_count_r);
      REG_BOX_COUNT:  prdata = 32'(box_count_r);
      default:        prdata = '0;
    endcase
  end

  // Clamp the counts to the table depths.
  logic [ECNT_W-1:0] ne_w;
  logic [BCNT_W-1:0] nb_w;
  assign ne_w = (edge_count_r > ECNT_W'(MAX_EDGES)) ? ECNT_W'(MAX_EDGES) : edge_count_r;
  assign nb_w = (box_count_r > BCNT_W'(MAX_BOXES)) ? BCNT_W'(MAX_BOXES) : box_count_r;

  // ---------------------------------------------------------------------------
  // Input transfer decode
  // ---------------------------------------------------------------------------
  logic [1:0] state_r, state_nxt;
  logic       in_xfer;
  logic       load_edge, load_box, start_query;
  entry_t     in_entry;

  assign in_ready    = (state_r == ST_IDLE);
  assign in_xfer     = in_valid & in_ready;
  assign in_entry    = '{a: in_coord_a, b: in_coord_b, c: in_coord_c, d: in_coord_d};
  // Loads beyond a table's depth are dropped.
  assign load_edge   = in_xfer && (in_opcode == OP_LOAD_EDGE)
                       && ({1'b0, in_entry_index} < (IDX_W + 1)'(MAX_EDGES));
  assign load_box    = in_xfer && (in_opcode == OP_LOAD_BOX)
                       && ({1'b0, in_entry_index} < (IDX_W + 1)'(MAX_BOXES));
  assign start_query = in_xfer && (in_opcode == OP_QUERY);

  // ---------------------------------------------------------------------------
  // Table memories: one write port (loads), one registered read port (scan)
  // ---------------------------------------------------------------------------
  entry_t edge_mem [MAX_EDGES];
  entry_t box_mem  [MAX_BOXES];
  entry_t edge_q_r;
  entry_t box_q_r;

  logic [ECNT_W-1:0] scan_idx_r, scan_idx_nxt;
  logic              edge_rd, box_rd;

  assign edge_rd = (state_r == ST_EDGE);
  assign box_rd  = (state_r == ST_BOX);

  // No read overlaps a write: input transfers stop while a scan runs.
  always_ff @(posedge clk) begin
    if (load_edge) begin
      edge_mem[in_entry_index[EDGE_AW-1:0]] <= in_entry;
    end
    if (edge_rd) begin
      edge_q_r <= edge_mem[scan_idx_r[EDGE_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (load_box) begin
      box_mem[in_entry_index[BOX_AW-1:0]] <= in_entry;
    end
    if (box_rd) begin
      box_q_r <= box_mem[scan_idx_r[BOX_AW-1:0]];
    end
  end

  // ---------------------------------------------------------------------------
  // Scan sequencer
  // ---------------------------------------------------------------------------
  coord_t px_r, py_r;
  logic   s1_vld_r, s1_box_r;
  logic   s2_vld_r, s2_box_r;
  logic   out_valid_r;
  logic   out_load;
  logic   pipe_empty;

  assign pipe_empty = !s1_vld_r && !s2_vld_r;
  assign out_load   = (state_r == ST_DRAIN) && pipe_empty && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt    = state_r;
    scan_idx_nxt = scan_idx_r;
    case (state_r)
      ST_IDLE: begin
        scan_idx_nxt = '0;
        if (start_query) begin
          if (ne_w != '0) begin
            state_nxt = ST_EDGE;
          end else if (nb_w != '0) begin
            state_nxt = ST_BOX;
          end else begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_EDGE: begin
        if (scan_idx_r + 1'b1 == ne_w) begin
          scan_idx_nxt = '0;
          state_nxt    = (nb_w != '0) ? ST_BOX : ST_DRAIN;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      ST_BOX: begin
        if (scan_idx_r + 1'b1 == ECNT_W'(nb_w)) begin
          scan_idx_nxt = '0;
          state_nxt    = ST_DRAIN;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        // Hold until the last entry has been counted and the output slot is free.
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      scan_idx_r <= '0;
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_idx_r <= scan_idx_nxt;
      s1_vld_r   <= edge_rd | box_rd;
      s2_vld_r   <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start_query) begin
      px_r <= in_coord_a;
      py_r <= in_coord_b;
    end
    s1_box_r <= box_rd;
    s2_box_r <= s1_box_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 1: read data back from a table; form the products or the box test
  // ---------------------------------------------------------------------------
  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int BW = COORD_WIDTH + 3;

  logic signed [DW-1:0] dx_w, dy_w, dpx_w, dpy_w;
  logic signed [PW-1:0] lhs_w, rhs_w;
  logic                 straddle_w;
  logic signed [BW-1:0] px2_w, py2_w, cx2_w, cy2_w;
  logic signed [BW-1:0] xlo_w, xhi_w, ylo_w, yhi_w;
  logic                 box_hit_w;

  // Edge crosses the ray when (py-y1)*dx vs (px-x1)*dy orders as the sign of dy.
  assign dx_w       = DW'(edge_q_r.c) - DW'(edge_q_r.a);
  assign dy_w       = DW'(edge_q_r.d) - DW'(edge_q_r.b);
  assign dpx_w      = DW'(px_r) - DW'(edge_q_r.a);
  assign dpy_w      = DW'(py_r) - DW'(edge_q_r.b);
  assign lhs_w      = PW'(dpy_w) * PW'(dx_w);
  assign rhs_w      = PW'(dpx_w) * PW'(dy_w);
  assign straddle_w = ((edge_q_r.b < py_r) && (edge_q_r.d > py_r))
                   || ((edge_q_r.b > py_r) && (edge_q_r.d < py_r));

  // Doubled coordinates keep the half-size bounds exact.
  assign px2_w     = BW'(px_r) + BW'(px_r);
  assign py2_w     = BW'(py_r) + BW'(py_r);
  assign cx2_w     = BW'(box_q_r.a) + BW'(box_q_r.a);
  assign cy2_w     = BW'(box_q_r.b) + BW'(box_q_r.b);
  assign xlo_w     = cx2_w - BW'(box_q_r.c);
  assign xhi_w     = cx2_w + BW'(box_q_r.c);
  assign ylo_w     = cy2_w - BW'(box_q_r.d);
  assign yhi_w     = cy2_w + BW'(box_q_r.d);
  assign box_hit_w = (px2_w >= xlo_w) && (px2_w <= xhi_w)
                  && (py2_w >= ylo_w) && (py2_w <= yhi_w);

  logic signed [PW-1:0] lhs_r, rhs_r;
  logic                 straddle_r, dy_neg_r, box_hit_r;

  always_ff @(posedge clk) begin
    lhs_r      <= lhs_w;
    rhs_r      <= rhs_w;
    straddle_r <= straddle_w;
    dy_neg_r   <= dy_w[DW-1];
    box_hit_r  <= box_hit_w;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: compare the products and accumulate
  // ---------------------------------------------------------------------------
  logic              edge_hit;
  logic [ECNT_W-1:0] cnt_r;
  logic              in_box_r;

  assign edge_hit = straddle_r && (dy_neg_r ? (lhs_r < rhs_r) : (lhs_r > rhs_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      in_box_r <= 1'b0;
    end else if (start_query) begin
      cnt_r    <= '0;
      in_box_r <= 1'b0;
    end else if (s2_vld_r) begin
      if (s2_box_r) begin
        in_box_r <= in_box_r | box_hit_r;
      end else if (edge_hit && (cnt_r != '1)) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: hold the result until its transfer
  // ---------------------------------------------------------------------------
  logic              occupied_r;
  logic [ECNT_W-1:0] crossing_r;
  logic              out_box_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      occupied_r <= !(cnt_r[0] && !in_box_r);
      crossing_r <= cnt_r;
      out_box_r  <= in_box_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_occupied       = occupied_r;
  assign out_crossing_count = crossing_r;
  assign out_in_box         = out_box_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `PIPBO_ASSERT(a_ready_pipe_empty, in_ready |-> pipe_empty, "input taken while scan in flight")
  `PIPBO_ASSERT(a_cnt_bound, cnt_r <= ECNT_W'(MAX_EDGES), "crossing count exceeds table depth")
  `PIPBO_ASSERT(a_s2_not_idle, s2_vld_r |-> (state_r != ST_IDLE), "stage 2 active while idle")
  `PIPBO_ASSERT(a_out_from_drain, $rose(out_valid_r) |-> ($past(state_r) == ST_DRAIN),
    "result raised outside drain")

endmodule
